[rtl/amcs_pkg.sv]
// amcs_pkg: shared types, widths and codes for the approximate match column step
// used by amcs_myers_step, amcs_scan and approx_match_column_step_core
// no dependencies
package amcs_pkg;

    // fixed field widths
    localparam int LEN_W      = 7;   // pattern length, row numbers up to 65
    localparam int DIST_W     = 6;   // edit distance
    localparam int SCORE_W    = 8;   // running score of the back scan
    localparam int SYM_W      = 8;   // text symbol
    localparam int IWIDTH_W   = 32;  // interval width
    localparam int STATUS_W   = 2;
    localparam int S_TDATA_W  = 40;  // symbol + interval width
    localparam int M_TDATA_W  = 16;  // prefix length + distance, padded
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // defaults of the top level parameters
    localparam int PATTERN_MAX_DEF = 64;
    localparam int ALPHABET_DEF    = 4;

    // rows examined per cycle by the back scan
    localparam int SCAN_ROWS = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LENGTH     = 3'd0,
        REG_MAX_DISTANCE       = 3'd1,
        REG_MAX_INTERVAL_WIDTH = 3'd2,
        REG_SKIP_PREFIX        = 3'd3,
        REG_EQ_SYMBOL_0        = 3'd4,
        REG_EQ_SYMBOL_1        = 3'd5,
        REG_EQ_SYMBOL_2        = 3'd6,
        REG_EQ_SYMBOL_3        = 3'd7
    } cfg_idx_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_CONTINUE = 2'd0,
        STATUS_SUCCESS  = 2'd1,
        STATUS_STOP     = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_SCAN,
        ST_EMIT
    } state_t;

    // row decision right after a vector update
    typedef struct packed {
        logic extend;     // limit row moves one row down
        logic back_scan;  // limit row must be searched upward
    } row_flags_t;

    // back scan position and score
    typedef struct packed {
        logic [LEN_W-1:0]   idx;
        logic [SCORE_W-1:0] score;
    } scan_ctl_t;

    typedef struct packed {
        scan_ctl_t ctl;
        logic      hit;        // row within limit found at ctl.idx
        logic      exhausted;  // reached row zero with no hit
    } scan_res_t;

    // register index of the equality vector of symbol a
    function automatic cfg_idx_t eq_index(input int a);
        eq_index = cfg_idx_t'(CFG_IDX_W'(int'(REG_EQ_SYMBOL_0) + a));
    endfunction

endpackage

[rtl/approx_match_column_step_core.sv]
// approx_match_column_step_core: top level of the approximate match column step
// instantiates amcs_myers_step and amcs_scan; depends on amcs_pkg
//
// Keeps one edit-distance column of a configured pattern as bit-parallel plus
// and minus vectors, together with the deepest row within the distance limit
// and its distance. Each input beat either restarts the column (tuser high)
// or advances it by one text symbol; symbols at or above the alphabet size
// match nothing. Every input beat gives exactly one output beat with a status
// of continue, success (prefix length and distance) or stop. Once stopped,
// symbols are ignored until a restart. An item passes through accept, vector
// update and result; after a cutoff, when the limit row must be searched
// upward, a back scan between update and result walks the column in steps of
// up to 8 rows, starting from the old limit row, and runs even when the limit
// row is row zero; the result step waits until the output register is free.
// The input is taken only between items; a finished result waits in the
// output register without holding up the next input beat. Configuration
// writes are taken at any time but must only be issued while idle.
module approx_match_column_step_core #(
    parameter int PATTERN_MAX = amcs_pkg::PATTERN_MAX_DEF,
    parameter int ALPHABET    = amcs_pkg::ALPHABET_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration write port
    input  logic                           cfg_wr_en,
    input  logic [amcs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [amcs_pkg::CFG_DATA_W-1:0] cfg_data,
    // input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [amcs_pkg::S_TDATA_W-1:0]  s_tdata,   // [7:0] symbol, [39:8] interval_width
    input  logic                           s_tuser,   // [0] restart
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [amcs_pkg::M_TDATA_W-1:0]  m_tdata,   // [6:0] prefix_length, [12:7] distance
    output logic [amcs_pkg::STATUS_W-1:0]   m_tuser    // [1:0] status
);
    import amcs_pkg::*;

    localparam int AW = $clog2(ALPHABET);

    // configuration registers
    logic [LEN_W-1:0]       pattern_length_reg;
    logic [DIST_W-1:0]      max_distance_reg;
    logic [IWIDTH_W-1:0]    max_width_reg;
    logic                   skip_prefix_reg;
    logic [PATTERN_MAX-1:0] eq_reg [ALPHABET];

    // item and column state
    state_t                 state_reg, state_next;
    logic                   restart_reg, restart_next;
    logic [SYM_W-1:0]       symbol_reg, symbol_next;
    logic [IWIDTH_W-1:0]    width_reg, width_next;
    logic [PATTERN_MAX-1:0] plus_reg, plus_next;
    logic [PATTERN_MAX-1:0] minus_reg, minus_next;
    logic [LEN_W-1:0]       limit_row_reg, limit_row_next;
    logic [DIST_W-1:0]      limit_dist_reg, limit_dist_next;
    scan_ctl_t              scan_reg, scan_next;

    // output register
    logic                   m_valid_reg, m_valid_next;
    status_t                status_reg, status_next;
    logic [LEN_W-1:0]       plen_reg, plen_next;
    logic [DIST_W-1:0]      dist_reg, dist_next;

    // effective length and distance limit
    logic [LEN_W-1:0]       m_eff;
    logic [DIST_W-1:0]      k_eff;
    logic [PATTERN_MAX-1:0] msk;
    logic [PATTERN_MAX-1:0] eq_sel;
    logic [PATTERN_MAX-1:0] upd_plus, upd_minus;
    row_flags_t             flags;
    scan_res_t              scan_res;
    logic                   out_free;

    // ---------------- configuration ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_length_reg <= LEN_W'(64);
            max_distance_reg   <= '0;
            max_width_reg      <= '0;
            skip_prefix_reg    <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_index))
                REG_PATTERN_LENGTH:     pattern_length_reg <= cfg_data[LEN_W-1:0];
                REG_MAX_DISTANCE:       max_distance_reg   <= cfg_data[DIST_W-1:0];
                REG_MAX_INTERVAL_WIDTH: max_width_reg      <= cfg_data[IWIDTH_W-1:0];
                REG_SKIP_PREFIX:        skip_prefix_reg    <= cfg_data[0];
                default: ;  // equality vectors are written below
            endcase
        end
    end

    // one equality vector per alphabet symbol, bits past the pattern width dropped
    for (genvar a = 0; a < ALPHABET; a++) begin : g_eq
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                eq_reg[a] <= '0;
            end else if (cfg_wr_en && cfg_idx_t'(cfg_index) == eq_index(a)) begin
                eq_reg[a] <= cfg_data[PATTERN_MAX-1:0];
            end
        end
    end

    // clamp length to 1..PATTERN_MAX and distance below the length
    always_comb begin
        if (pattern_length_reg == '0) begin
            m_eff = LEN_W'(1);
        end else if (pattern_length_reg > LEN_W'(PATTERN_MAX)) begin
            m_eff = LEN_W'(PATTERN_MAX);
        end else begin
            m_eff = pattern_length_reg;
        end
        if (LEN_W'(max_distance_reg) >= m_eff) begin
            k_eff = DIST_W'(m_eff - LEN_W'(1));
        end else begin
            k_eff = max_distance_reg;
        end
        for (int i = 0; i < PATTERN_MAX; i++) begin
            msk[i] = (LEN_W'(i) < m_eff);
        end
        // wildcard symbols match no position
        if (symbol_reg < SYM_W'(ALPHABET)) begin
            eq_sel = eq_reg[symbol_reg[AW-1:0]] & msk;
        end else begin
            eq_sel = '0;
        end
    end

    // ---------------- datapath units ----------------
    amcs_myers_step #(
        .PATTERN_MAX(PATTERN_MAX)
    ) u_myers (
        .eq        (eq_sel),
        .pv        (plus_reg & msk),
        .mv        (minus_reg & msk),
        .msk       (msk),
        .row       (limit_row_reg),
        .m         (m_eff),
        .plus_next (upd_plus),
        .minus_next(upd_minus),
        .flags     (flags)
    );

    amcs_scan #(
        .PATTERN_MAX(PATTERN_MAX)
    ) u_scan (
        .plus_vec (plus_reg),
        .minus_vec(minus_reg),
        .k        (k_eff),
        .ctl_in   (scan_reg),
        .res      (scan_res)
    );

    // ---------------- sequencer ----------------
    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        state_next      = state_reg;
        restart_next    = restart_reg;
        symbol_next     = symbol_reg;
        width_next      = width_reg;
        plus_next       = plus_reg;
        minus_next      = minus_reg;
        limit_row_next  = limit_row_reg;
        limit_dist_next = limit_dist_reg;
        scan_next       = scan_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        status_next     = status_reg;
        plen_next       = plen_reg;
        dist_next       = dist_reg;
        s_tready        = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    restart_next = s_tuser;
                    symbol_next  = s_tdata[SYM_W-1:0];
                    width_next   = s_tdata[SYM_W +: IWIDTH_W];
                    state_next   = ST_UPDATE;
                end
            end

            ST_UPDATE: begin
                state_next = ST_EMIT;
                if (restart_reg) begin
                    minus_next = '0;
                    if (skip_prefix_reg) begin
                        plus_next       = '0;
                        limit_row_next  = m_eff;
                        limit_dist_next = '0;
                    end else begin
                        plus_next       = '1;
                        limit_row_next  = LEN_W'(k_eff);
                        limit_dist_next = k_eff;
                    end
                end else if (limit_row_reg <= m_eff) begin
                    // stopped columns keep their state
                    plus_next  = upd_plus;
                    minus_next = upd_minus;
                    if (flags.extend) begin
                        limit_row_next = limit_row_reg + LEN_W'(1);
                    end else if (flags.back_scan) begin
                        scan_next.idx   = limit_row_reg;
                        scan_next.score = SCORE_W'(k_eff) + SCORE_W'(1);
                        state_next      = ST_SCAN;
                    end
                end
            end

            ST_SCAN: begin
                scan_next = scan_res.ctl;
                if (scan_res.hit) begin
                    limit_row_next  = scan_res.ctl.idx;
                    limit_dist_next = scan_res.ctl.score[DIST_W-1:0];
                    state_next      = ST_EMIT;
                end else if (scan_res.exhausted) begin
                    // no row within the limit: mark the column stopped
                    limit_row_next = m_eff + LEN_W'(1);
                    state_next     = ST_EMIT;
                end
            end

            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    status_next  = STATUS_CONTINUE;
                    plen_next    = '0;
                    dist_next    = '0;
                    if (limit_row_reg > m_eff) begin
                        status_next = STATUS_STOP;
                    end else if (max_width_reg == '0 || width_reg == IWIDTH_W'(1)) begin
                        // full match only
                        if (limit_row_reg == m_eff) begin
                            status_next = STATUS_SUCCESS;
                            plen_next   = m_eff;
                            dist_next   = limit_dist_reg;
                        end
                    end else if (width_reg <= max_width_reg) begin
                        // partial prefix match, row zero included
                        status_next = STATUS_SUCCESS;
                        plen_next   = limit_row_reg;
                        dist_next   = limit_dist_reg;
                    end
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_valid_reg    <= 1'b0;
            plus_reg       <= '1;
            minus_reg      <= '0;
            limit_row_reg  <= '0;
            limit_dist_reg <= '0;
        end else begin
            state_reg      <= state_next;
            m_valid_reg    <= m_valid_next;
            plus_reg       <= plus_next;
            minus_reg      <= minus_next;
            limit_row_reg  <= limit_row_next;
            limit_dist_reg <= limit_dist_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        restart_reg <= restart_next;
        symbol_reg  <= symbol_next;
        width_reg   <= width_next;
        scan_reg    <= scan_next;
        status_reg  <= status_next;
        plen_reg    <= plen_next;
        dist_reg    <= dist_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {{(M_TDATA_W - LEN_W - DIST_W){1'b0}}, dist_reg, plen_reg};

`ifndef SYNTHESIS
    // an accepted beat always starts the vector update
    a_accept_to_update: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> state_reg == ST_UPDATE)
        else $error("accepted beat did not start an update");

    // the scan never runs on with a score already within the limit
    a_scan_score: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> scan_reg.score > SCORE_W'(k_eff))
        else $error("back scan running past a hit");

    // a stop result carries no prefix and no distance
    a_stop_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == STATUS_STOP |-> m_tdata == '0)
        else $error("stop result with nonzero payload");

    // limit row stays within one past the deepest possible row
    a_row_range: assert property (@(posedge aclk) disable iff (!aresetn)
        limit_row_reg <= LEN_W'(PATTERN_MAX + 1))
        else $error("limit row out of range");
`endif

endmodule

[rtl/amcs_myers_step.sv]
// amcs_myers_step: one column update of the bit-parallel edit distance vectors
// and the row decision for the limit row; depends on amcs_pkg
module amcs_myers_step #(
    parameter int PATTERN_MAX = amcs_pkg::PATTERN_MAX_DEF
) (
    input  logic [PATTERN_MAX-1:0]    eq,
    input  logic [PATTERN_MAX-1:0]    pv,
    input  logic [PATTERN_MAX-1:0]    mv,
    input  logic [PATTERN_MAX-1:0]    msk,
    input  logic [amcs_pkg::LEN_W-1:0] row,
    input  logic [amcs_pkg::LEN_W-1:0] m,
    output logic [PATTERN_MAX-1:0]    plus_next,
    output logic [PATTERN_MAX-1:0]    minus_next,
    output amcs_pkg::row_flags_t      flags
);
    import amcs_pkg::*;

    localparam int IDX_W = $clog2(PATTERN_MAX);

    logic [PATTERN_MAX-1:0] xv, xh, ph, mh, phs;
    logic [LEN_W-1:0]       row_m1;
    logic                   e_bit, m_bit;

    always_comb begin
        xv = eq | mv;
        xh = (((eq & pv) + pv) ^ pv) | eq;
        ph = mv | ~(xh | pv);
        mh = pv & xh;
        phs = {ph[PATTERN_MAX-2:0], 1'b1};
        plus_next  = ({mh[PATTERN_MAX-2:0], 1'b0} | ~(xv | phs)) & msk;
        minus_next = phs & xv & msk;

        row_m1 = row - LEN_W'(1);
        e_bit  = (row < m) ? eq[row[IDX_W-1:0]] : 1'b0;
        m_bit  = (row < m) ? mh[row[IDX_W-1:0]] : 1'b0;
        flags.extend    = e_bit | m_bit;
        flags.back_scan = (row == '0) ? 1'b1 : ph[row_m1[IDX_W-1:0]];
    end

endmodule

[rtl/amcs_scan.sv]
// amcs_scan: walks the updated column upward, up to SCAN_ROWS rows per cycle,
// looking for the deepest row within the distance limit; depends on amcs_pkg
module amcs_scan #(
    parameter int PATTERN_MAX = amcs_pkg::PATTERN_MAX_DEF
) (
    input  logic [PATTERN_MAX-1:0]     plus_vec,
    input  logic [PATTERN_MAX-1:0]     minus_vec,
    input  logic [amcs_pkg::DIST_W-1:0] k,
    input  amcs_pkg::scan_ctl_t        ctl_in,
    output amcs_pkg::scan_res_t        res
);
    import amcs_pkg::*;

    localparam int IDX_W = $clog2(PATTERN_MAX);

    logic [LEN_W-1:0]   idx;
    logic [SCORE_W-1:0] score;
    logic               hit;

    always_comb begin
        idx   = ctl_in.idx;
        score = ctl_in.score;
        hit   = 1'b0;
        for (int j = 0; j < SCAN_ROWS; j++) begin
            if (!hit && idx != '0) begin
                idx = idx - LEN_W'(1);
                if (plus_vec[idx[IDX_W-1:0]]) begin
                    score = score - SCORE_W'(1);
                    if (score <= SCORE_W'(k)) begin
                        hit = 1'b1;
                    end
                end else if (minus_vec[idx[IDX_W-1:0]]) begin
                    score = score + SCORE_W'(1);
                end
            end
        end
        res.ctl.idx   = idx;
        res.ctl.score = score;
        res.hit       = hit;
        res.exhausted = !hit && (idx == '0);
    end

endmodule

[tb/approx_match_column_step_core_test.sv]
// approx_match_column_step_core_test: self-checking bench for the approximate match column step
// keeps its own bit-parallel edit-distance column and checks every result beat against it
// depends on amcs_pkg and approx_match_column_step_core
module approx_match_column_step_core_test;
    import amcs_pkg::*;

    localparam int ROWS_MAX = PATTERN_MAX_DEF;
    localparam int SYMBOLS  = ALPHABET_DEF;
    localparam int SETTING_ITEMS = 35;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [STATUS_W-1:0]   m_tuser;

    approx_match_column_step_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // [7:0] symbol, [39:8] interval_width
        .s_tuser   (s_tuser),    // [0] restart
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // [6:0] prefix_length, [12:7] distance
        .m_tuser   (m_tuser)     // [1:0] status
    );

    // 10 unit clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    typedef struct {
        status_t            status;
        logic [LEN_W-1:0]   prefix_len;
        logic [DIST_W-1:0]  distance;
    } column_result_t;

    // register copies, reset values of the block
    logic [LEN_W-1:0]    pat_len_reg  = 7'd64;
    logic [DIST_W-1:0]   max_dist_reg = '0;
    logic [31:0]         max_iw_reg   = '0;
    logic                skip_reg     = 1'b0;
    logic [63:0]         eq_vec [SYMBOLS];

    // column state
    logic [63:0] plus_vec  = '1;
    logic [63:0] minus_vec = '0;
    int unsigned limit_row_q  = 0;
    int unsigned limit_dist_q = 0;

    // pattern behind the equality vectors, used to build matching text
    logic [1:0] pattern_sym [ROWS_MAX];

    column_result_t expected_results [$];

    int tx_idle_pct = 26;
    int rx_idle_pct = 49;
    int items_sent = 0;
    int results_checked = 0;
    int settings_used = 0;
    int mismatches = 0;

    initial begin
        for (int a = 0; a < SYMBOLS; a++) eq_vec[a] = '0;
    end

    // ---------------------------------------------------------------
    // column predictor
    // ---------------------------------------------------------------

    // effective row count: 0 counts as 1, above the maximum saturates
    function automatic int unsigned eff_rows();
        if (pat_len_reg == 0) return 1;
        if (pat_len_reg > ROWS_MAX) return ROWS_MAX;
        return pat_len_reg;
    endfunction

    function automatic void advance_column(int unsigned m, int unsigned k, int unsigned sym);
        logic [63:0] msk, eq, pv, mv, xv, xh, ph, mh, phs;
        int unsigned row, score, found, i;
        logic e_bit, m_bit, p_bit;
        msk = (m >= 64) ? '1 : ((64'd1 << m) - 64'd1);
        eq = (sym < SYMBOLS) ? (eq_vec[sym] & msk) : '0;
        pv = plus_vec & msk;
        mv = minus_vec & msk;
        row = limit_row_q;

        // one Myers column update, vectors held to m bits
        xv = eq | mv;
        xh = (((eq & pv) + pv) ^ pv) | eq;
        ph = mv | ~(xh | pv);
        mh = pv & xh;
        phs = (ph << 1) | 64'd1;
        plus_vec  = ((mh << 1) | ~(xv | phs)) & msk;
        minus_vec = (phs & xv) & msk;

        e_bit = (row < m) ? eq[row] : 1'b0;
        m_bit = (row < m) ? mh[row] : 1'b0;
        p_bit = (row == 0) ? 1'b1 : ph[row-1];

        if (e_bit || m_bit) begin
            limit_row_q = row + 1;
        end else if (p_bit) begin
            // cutoff: walk up from the old limit row until the score is back in range
            score = k + 1;
            found = m + 1;
            i = row;
            while (i > 0) begin
                i--;
                if (plus_vec[i]) begin
                    score--;
                    if (score <= k) begin
                        found = i;
                        limit_dist_q = score & 63;
                        break;
                    end
                end else if (minus_vec[i]) begin
                    score++;
                end
            end
            limit_row_q = found;
        end
    endfunction

    function automatic column_result_t column_step(logic restart, logic [7:0] sym,
                                                   logic [31:0] iw);
        column_result_t r;
        int unsigned m, k;
        m = eff_rows();
        k = (max_dist_reg >= m) ? m - 1 : max_dist_reg;
        r.status = STATUS_CONTINUE;
        r.prefix_len = '0;
        r.distance = '0;

        if (restart) begin
            minus_vec = '0;
            if (skip_reg) begin
                plus_vec = '0;
                limit_row_q = m;
                limit_dist_q = 0;
            end else begin
                plus_vec = '1;
                limit_row_q = k;
                limit_dist_q = k;
            end
        end else if (limit_row_q <= m) begin
            advance_column(m, k, sym);
        end
        // a stopped column ignores symbols until the next restart

        if (limit_row_q > m) begin
            r.status = STATUS_STOP;
        end else if (max_iw_reg == 0 || iw == 1) begin
            // full match rule
            if (limit_row_q == m) begin
                r.status = STATUS_SUCCESS;
                r.prefix_len = LEN_W'(m);
                r.distance = DIST_W'(limit_dist_q);
            end
        end else if (iw <= max_iw_reg) begin
            // interval narrow enough: any prefix, also the empty one
            r.status = STATUS_SUCCESS;
            r.prefix_len = LEN_W'(limit_row_q);
            r.distance = DIST_W'(limit_dist_q);
        end
        return r;
    endfunction

    // ---------------------------------------------------------------
    // result side: random stall and beat check
    // ---------------------------------------------------------------

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge aclk) begin : result_check
        column_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $error("result beat with no item outstanding: status %0d", m_tuser);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                results_checked++;
                if (m_tuser !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_tuser);
                    mismatches++;
                end
                if (m_tdata[6:0] !== want.prefix_len) begin
                    $error("prefix_length: expected %0d, got %0d", want.prefix_len, m_tdata[6:0]);
                    mismatches++;
                end
                if (m_tdata[12:7] !== want.distance) begin
                    $error("distance: expected %0d, got %0d", want.distance, m_tdata[12:7]);
                    mismatches++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // drivers
    // ---------------------------------------------------------------

    // one input beat; valid stays high after acceptance so back-to-back beats need no gap
    task automatic send_item(logic restart, logic [7:0] sym, logic [31:0] iw);
        @(negedge aclk);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {iw, sym};
        s_tuser  <= restart;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_results.push_back(column_step(restart, sym, iw));
        items_sent++;
    endtask

    // drop valid and let every outstanding result drain
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [63:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        case (idx)
            REG_PATTERN_LENGTH:     pat_len_reg  = value[LEN_W-1:0];
            REG_MAX_DISTANCE:       max_dist_reg = value[DIST_W-1:0];
            REG_MAX_INTERVAL_WIDTH: max_iw_reg   = value[31:0];
            REG_SKIP_PREFIX:        skip_reg     = value[0];
            REG_EQ_SYMBOL_0:        eq_vec[0]    = value;
            REG_EQ_SYMBOL_1:        eq_vec[1]    = value;
            REG_EQ_SYMBOL_2:        eq_vec[2]    = value;
            REG_EQ_SYMBOL_3:        eq_vec[3]    = value;
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // random pattern of len rows; bits above the pattern are junk the block must mask
    task automatic load_pattern(int unsigned len);
        logic [63:0] vec [SYMBOLS];
        cfg_idx_t eq_reg [SYMBOLS];
        eq_reg = '{REG_EQ_SYMBOL_0, REG_EQ_SYMBOL_1, REG_EQ_SYMBOL_2, REG_EQ_SYMBOL_3};
        for (int i = 0; i < ROWS_MAX; i++) pattern_sym[i] = 2'($urandom_range(SYMBOLS - 1));
        for (int a = 0; a < SYMBOLS; a++) begin
            vec[a] = {$urandom, $urandom};
            for (int i = 0; i < len; i++) vec[a][i] = (pattern_sym[i] == a);
            write_reg(eq_reg[a], vec[a]);
        end
    endtask

    task automatic write_setting(int unsigned len, int unsigned dist_max, logic [31:0] iw_limit,
                                 logic skip);
        write_reg(REG_PATTERN_LENGTH, 64'(len));
        write_reg(REG_MAX_DISTANCE, 64'(dist_max));
        write_reg(REG_MAX_INTERVAL_WIDTH, 64'(iw_limit));
        write_reg(REG_SKIP_PREFIX, 64'(skip));
        settings_used++;
    endtask

    // interval widths around the interesting boundaries
    function automatic logic [31:0] pick_width();
        case ($urandom_range(9))
            0: return 32'd0;
            1: return 32'd1;
            2: return max_iw_reg;
            3: return max_iw_reg + 32'd1;
            4: return 32'hFFFF_FFFF;
            5: return $urandom;
            default: return 32'($urandom_range(20));
        endcase
    endfunction

    // restart, then text that mostly follows the pattern with a few edits and wildcards
    task automatic run_sequence();
        int unsigned m, pos, run_len;
        logic [7:0] sym;
        m = eff_rows();
        send_item(1'b1, 8'($urandom), pick_width());
        pos = skip_reg ? $urandom_range(m - 1) : 0;
        run_len = $urandom_range(1, m + 3);
        repeat (run_len) begin
            case ($urandom_range(19))
                0: sym = 8'($urandom_range(SYMBOLS, 255));          // wildcard
                1, 2: sym = 8'($urandom_range(SYMBOLS - 1));      // substitution or insertion
                3: begin                                          // deletion
                    pos++;
                    sym = (pos < m) ? 8'(pattern_sym[pos]) : 8'($urandom_range(SYMBOLS - 1));
                end
                default: sym = (pos < m) ? 8'(pattern_sym[pos]) : 8'($urandom_range(SYMBOLS - 1));
            endcase
            pos++;
            send_item(1'b0, sym, pick_width());
        end
    endtask

    task automatic random_setting();
        int unsigned len, dist_max;
        logic [31:0] iw_limit;
        case ($urandom_range(9))
            0: len = ROWS_MAX;
            1: len = $urandom_range(ROWS_MAX + 1, 127);
            2: len = 0;
            default: len = $urandom_range(1, 16);
        endcase
        case ($urandom_range(7))
            0: dist_max = 63;
            1: dist_max = $urandom_range(63);
            default: dist_max = $urandom_range(3);
        endcase
        case ($urandom_range(9))
            0, 1, 2: iw_limit = 32'd0;
            3: iw_limit = 32'hFFFF_FFFF;
            4: iw_limit = $urandom;
            default: iw_limit = 32'($urandom_range(1, 20));
        endcase
        write_setting(len, dist_max, iw_limit, 1'($urandom_range(1)));
        load_pattern(eff_rows());
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // registers left at reset: 64 rows, distance 0, empty equality vectors
    task automatic test_reset_state();
        send_item(1'b0, 8'd0, 32'd0);
        send_item(1'b1, 8'd255, 32'd1);
    endtask

    // exact match to success, a step past it, wildcards down to stop, ignored symbol, restart
    task automatic test_exact_match();
        wait_idle();
        write_setting(6, 1, 32'd0, 1'b0);
        load_pattern(6);
        send_item(1'b1, 8'd0, 32'd7);
        for (int i = 0; i < 6; i++) send_item(1'b0, 8'(pattern_sym[i]), (i == 5) ? 32'd1 : 32'd9);
        send_item(1'b0, 8'd2, 32'd1);
        send_item(1'b0, 8'd255, 32'd3);
        send_item(1'b0, 8'd4, 32'd3);
        send_item(1'b0, 8'd128, 32'd3);
        send_item(1'b0, 8'(pattern_sym[0]), 32'd3);
        send_item(1'b1, 8'd0, 32'd0);
    endtask

    // prefix success by interval width, including the empty prefix at row zero
    task automatic test_partial_match();
        wait_idle();
        write_setting(8, 0, 32'd5, 1'b0);
        load_pattern(8);
        send_item(1'b1, 8'd0, 32'd3);
        send_item(1'b0, 8'(pattern_sym[0]), 32'd5);
        send_item(1'b0, 8'(pattern_sym[1]), 32'd6);
        send_item(1'b0, 8'(pattern_sym[2]), 32'd0);
        send_item(1'b0, 8'(pattern_sym[3]), 32'd1);
        send_item(1'b0, 8'(pattern_sym[4]), 32'hFFFF_FFFF);
    endtask

    // length 0 and over-range, saturated distance, prefix skipping, shrink while stopped
    task automatic test_length_edges();
        wait_idle();
        write_setting(0, 63, 32'd0, 1'b0);
        load_pattern(1);
        send_item(1'b1, 8'd0, 32'd0);
        send_item(1'b0, 8'(pattern_sym[0]), 32'd0);
        wait_idle();
        write_setting(127, 63, 32'hFFFF_FFFF, 1'b1);
        load_pattern(ROWS_MAX);
        send_item(1'b1, 8'd0, 32'hFFFF_FFFF);
        send_item(1'b0, 8'd3, 32'd2);
        wait_idle();
        write_setting(16, 0, 32'd0, 1'b0);
        send_item(1'b1, 8'd0, 32'd4);
        send_item(1'b0, 8'd200, 32'd4);
        wait_idle();
        write_reg(REG_PATTERN_LENGTH, 64'd8);
        send_item(1'b0, 8'(pattern_sym[0]), 32'd4);
    endtask

    // mostly well-formed sequences, some raw noise, new settings every few dozen beats
    task automatic test_random_mix(int tx_pct, int rx_pct, int count);
        int target, block_end;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        target = items_sent + count;
        while (items_sent < target) begin
            wait_idle();
            random_setting();
            block_end = items_sent + SETTING_ITEMS;
            while (items_sent < block_end && items_sent < target) begin
                if ($urandom_range(4) == 0)
                    send_item(($urandom_range(7) == 0), 8'($urandom), $urandom);
                else
                    run_sequence();
            end
        end
    endtask

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_state();
        test_exact_match();
        test_partial_match();
        test_length_edges();

        test_random_mix(26, 49, 200);
        test_random_mix(49, 26, 200);
        test_random_mix(0, 0, 200);

        // drain, then give the block time for a last back scan
        wait_idle();
        repeat (12) @(posedge aclk);

        $display("column step run: %0d beats in, %0d results checked, %0d register settings",
                 items_sent, results_checked, settings_used);
        $display("idle mixes sender/receiver 26/49, 49/26 and none; %0d mismatches", mismatches);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // hard stop far beyond the slowest legal run
    initial begin
        #3_000_000;
        $display("timeout with %0d results outstanding", expected_results.size());
        $display("TB_ERROR");
        $finish;
    end

endmodule

[filelist.f]
rtl/amcs_pkg.sv
rtl/amcs_myers_step.sv
rtl/amcs_scan.sv
rtl/approx_match_column_step_core.sv
tb/approx_match_column_step_core_test.sv
